### hdl/bounded_array_list_macros.svh
// Assertion helpers shared by the list RTL.
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BAL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bal_pkg.sv
package bal_pkg;

    // Field widths
    localparam int OP_W      = 3;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 3;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_READ      = 3'd6
    } t_op;

    // Response status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

### hdl/bal_ram.sv
module bal_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bal_pkg::WORD_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [bal_pkg::WORD_W-1:0] o_rdata
);
    import bal_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bounded_array_list.sv
// Sequence: a read, back insert, back delete, rejected or unknown request goes from S_IDLE
//   straight to S_FIN, which registers the response; a shift passes through S_MOVE first.
// Throughput: one request at a time; the next is taken once the response is registered.
//   The list memory (one read, one write port) moves one entry per cycle during a shift.
// Reset: synchronous, active low; clears the fill count and handshake state. List
//   contents are not cleared and only slots below the count are ever read.
`include "bounded_array_list_macros.svh"

module bounded_array_list #(
    parameter int CAPACITY = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [2:0] op, [34:3] value, [37:35] position, [39:38] zero
    input  logic [bal_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [1:0] status, [5:2] fill_count, [37:6] read_value, [39:38] zero
    output logic [bal_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import bal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOVE = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Control registers
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_m_valid, n_m_valid;
    logic                r_wr_pend, n_wr_pend;
    logic [CW-1:0]       r_left, n_left;

    // Payload registers
    t_status             r_status, n_status;
    logic                r_is_rd, n_is_rd;
    logic                r_ins, n_ins;
    logic                r_dn, n_dn;
    logic [AW-1:0]       r_pos, n_pos;
    logic [WORD_W-1:0]   r_value, n_value;
    logic [AW-1:0]       r_src, n_src;
    logic [AW-1:0]       r_wr_addr, n_wr_addr;
    logic [M_TDATA_W-1:0] r_m_data, n_m_data;

    // Request fields
    t_op                 in_op;
    logic [WORD_W-1:0]   in_value;
    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       cnt_x;
    logic                full;
    logic                empty;
    logic                accept;

    // Decode results
    t_status             d_status;
    logic [CW-1:0]       d_count;
    logic                d_move;
    logic                d_ins;
    logic                d_dn;
    logic [XW-1:0]       d_left;
    logic [XW-1:0]       d_src;
    logic                d_bwe;
    logic                d_rd;
    logic [XW-1:0]       top_x;
    logic [XW-1:0]       ins_pos;
    logic [XW-1:0]       del_pos;
    logic [XW-1:0]       baddr_x;

    // Memory port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic                move_done;

    assign in_op    = t_op'(i_s_axis_tdata[2:0]);
    assign in_value = i_s_axis_tdata[34:3];
    assign pos_x    = XW'(i_s_axis_tdata[37:35]);
    assign cnt_x    = XW'(r_count);
    assign full     = (cnt_x == CAP_X);
    assign empty    = (cnt_x == '0);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign top_x   = full ? (CAP_X - XW'(1)) : cnt_x;
    assign ins_pos = (in_op == OP_INS_AT) ? pos_x : '0;
    assign del_pos = (in_op == OP_DEL_AT) ? pos_x : '0;
    assign baddr_x = full ? (CAP_X - XW'(1)) : cnt_x;

    // Request decode against the current fill count
    always_comb begin
        d_status = ST_OK;
        d_count  = r_count;
        d_move   = 1'b0;
        d_ins    = 1'b0;
        d_dn     = 1'b1;
        d_left   = '0;
        d_src    = '0;
        d_bwe    = 1'b0;
        d_rd     = 1'b0;
        unique case (in_op)
            OP_INS_FRONT, OP_INS_AT: begin
                if (in_op == OP_INS_AT && (pos_x > cnt_x || pos_x >= CAP_X)) begin
                    d_status = ST_RANGE;
                end else begin
                    d_move   = 1'b1;
                    d_ins    = 1'b1;
                    d_dn     = 1'b1;
                    d_left   = top_x - ins_pos;
                    d_src    = top_x - XW'(1);
                    d_status = full ? ST_DROP : ST_OK;
                    d_count  = full ? r_count : CW'(r_count + 1'b1);
                end
            end
            OP_INS_BACK: begin
                d_bwe    = 1'b1;
                d_status = full ? ST_DROP : ST_OK;
                d_count  = full ? r_count : CW'(r_count + 1'b1);
            end
            OP_DEL_FRONT, OP_DEL_AT: begin
                if (empty) begin
                    d_status = ST_EMPTY;
                end else if (in_op == OP_DEL_AT && pos_x >= cnt_x) begin
                    d_status = ST_RANGE;
                end else begin
                    d_move  = 1'b1;
                    d_dn    = 1'b0;
                    d_left  = cnt_x - XW'(1) - del_pos;
                    d_src   = del_pos + XW'(1);
                    d_count = CW'(r_count - 1'b1);
                end
            end
            OP_DEL_BACK: begin
                if (empty) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_count = CW'(r_count - 1'b1);
                end
            end
            OP_READ: begin
                if (empty) begin
                    d_status = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    d_status = ST_RANGE;
                end else begin
                    d_rd = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign move_done = (r_left == '0) && !r_wr_pend;

    // Memory port selection: direct access on accept, shift traffic while moving
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_src;
        unique case (r_state)
            S_IDLE: begin
                ram_we    = accept && d_bwe;
                ram_waddr = AW'(baddr_x);
                ram_wdata = in_value;
                ram_re    = accept && d_rd;
                ram_raddr = AW'(pos_x);
            end
            S_MOVE: begin
                ram_re = (r_left != '0);
                if (r_wr_pend) begin
                    ram_we = 1'b1;
                end else if (move_done && r_ins) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = r_value;
                end
            end
            default: begin
            end
        endcase
    end

    bal_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_wr_pend = r_wr_pend;
        n_left    = r_left;
        n_status  = r_status;
        n_is_rd   = r_is_rd;
        n_ins     = r_ins;
        n_dn      = r_dn;
        n_pos     = r_pos;
        n_value   = r_value;
        n_src     = r_src;
        n_wr_addr = r_wr_addr;
        n_m_data  = r_m_data;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count   = d_count;
                    n_status  = d_status;
                    n_is_rd   = d_rd;
                    n_ins     = d_ins;
                    n_dn      = d_dn;
                    n_pos     = AW'(ins_pos);
                    n_value   = in_value;
                    n_src     = AW'(d_src);
                    n_left    = CW'(d_left);
                    n_wr_pend = 1'b0;
                    n_state   = d_move ? S_MOVE : S_FIN;
                end
            end
            S_MOVE: begin
                // One read per cycle; its data is written one slot over next cycle
                if (r_left != '0) begin
                    n_src     = r_dn ? AW'(r_src - 1'b1) : AW'(r_src + 1'b1);
                    n_wr_addr = r_dn ? AW'(r_src + 1'b1) : AW'(r_src - 1'b1);
                    n_left    = CW'(r_left - 1'b1);
                    n_wr_pend = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                end
                if (move_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_data  = {2'b00,
                                 (r_is_rd ? ram_rdata : {WORD_W{1'b0}}),
                                 CNT_W'(r_count),
                                 r_status};
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
            r_wr_pend <= 1'b0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            r_wr_pend <= n_wr_pend;
            r_left    <= n_left;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_is_rd   <= n_is_rd;
        r_ins     <= n_ins;
        r_dn      <= n_dn;
        r_pos     <= n_pos;
        r_value   <= n_value;
        r_src     <= n_src;
        r_wr_addr <= n_wr_addr;
        r_m_data  <= n_m_data;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // Checks
    `BAL_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, (r_count <= CW'(CAPACITY)), "fill count above capacity")
    `BAL_ASSERT_SAME(a_no_rw_clash, i_clk, i_rst_n, (ram_re && ram_we), (ram_waddr != ram_raddr), "read and write hit the same slot")
    `BAL_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, accept, (r_count == $past(r_count) || r_count == CW'($past(r_count) + 1'b1) || r_count == CW'($past(r_count) - 1'b1)), "fill count moved by more than one")

endmodule
